FILE: design/ffbp_pkg.sv
`default_nettype none

package ffbp_pkg;

  // field widths of the channels
  localparam int KIND_W   = 1;
  localparam int SIZE_W   = 27;
  localparam int NUMBER_W = 32;
  localparam int STATUS_W = 3;
  localparam int SEQ_W    = 32;
  localparam int TAG_W    = 16;
  localparam int INDEX_W  = 16;
  localparam int LENGTH_W = 11;
  localparam int PAUSE_W  = 9;
  localparam int BURST_W  = 5;
  localparam int MODE_W   = 2;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [MODE_W-1:0]   mode_t;

  // request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  // result status codes
  localparam status_t ST_FRAGMENT  = 3'd0;
  localparam status_t ST_ACCEPTED  = 3'd1;
  localparam status_t ST_DISABLED  = 3'd2;
  localparam status_t ST_TOO_LARGE = 3'd3;
  localparam status_t ST_IDLE      = 3'd4;

  // pacing modes
  localparam mode_t MODE_NONE       = 2'd0;
  localparam mode_t MODE_LIGHT      = 2'd1;
  localparam mode_t MODE_AGGRESSIVE = 2'd2;
  localparam mode_t MODE_KEYFRAME   = 2'd3;

  // register indexes on the configuration port
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  // pacing thresholds and burst rules
  localparam logic [SIZE_W-1:0] LIGHT_MIN_SIZE  = 27'd50000;
  localparam logic [SIZE_W-1:0] AGGR_MIN_SIZE   = 27'd2400;
  localparam logic [SIZE_W-1:0] KEY_TIER1_SIZE  = 27'd100000;
  localparam logic [SIZE_W-1:0] KEY_TIER2_SIZE  = 27'd300000;
  localparam logic [SIZE_W-1:0] KEY_TIER3_SIZE  = 27'd500000;

  localparam logic [BURST_W-1:0] LIGHT_BURST = 5'd20;
  localparam logic [PAUSE_W-1:0] LIGHT_PAUSE = 9'd50;
  localparam logic [BURST_W-1:0] AGGR_BURST  = 5'd4;
  localparam logic [PAUSE_W-1:0] AGGR_PAUSE  = 9'd200;
  localparam logic [BURST_W-1:0] KEY0_BURST  = 5'd8;
  localparam logic [PAUSE_W-1:0] KEY0_PAUSE  = 9'd100;
  localparam logic [BURST_W-1:0] KEY1_BURST  = 5'd6;
  localparam logic [PAUSE_W-1:0] KEY1_PAUSE  = 9'd150;
  localparam logic [BURST_W-1:0] KEY2_BURST  = 5'd4;
  localparam logic [PAUSE_W-1:0] KEY2_PAUSE  = 9'd200;
  localparam logic [BURST_W-1:0] KEY3_BURST  = 5'd2;
  localparam logic [PAUSE_W-1:0] KEY3_PAUSE  = 9'd300;

  // one result item
  typedef struct packed {
    status_t              status;
    logic [SEQ_W-1:0]     sequence_res;
    logic [TAG_W-1:0]     frame_tag;
    logic                 keyframe_mark;
    logic                 start_mark;
    logic                 end_mark;
    logic [INDEX_W-1:0]   fragment_index;
    logic [INDEX_W-1:0]   fragment_total;
    logic [LENGTH_W-1:0]  payload_length;
    logic [SIZE_W-1:0]    payload_offset;
    logic [PAUSE_W-1:0]   pause_us;
  } result_t;

endpackage

`default_nettype wire

FILE: design/ffbp_in_if.sv
`default_nettype none

interface ffbp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [ffbp_pkg::SIZE_W-1:0]    frame_size;
  logic [ffbp_pkg::NUMBER_W-1:0]  frame_id;
  logic                           is_keyframe;

  modport source(output valid, kind, frame_size, frame_id, is_keyframe, input ready);
  modport sink(input valid, kind, frame_size, frame_id, is_keyframe, output ready);
endinterface

`default_nettype wire

FILE: design/ffbp_out_if.sv
`default_nettype none

interface ffbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [ffbp_pkg::STATUS_W-1:0]  status;
  logic [ffbp_pkg::SEQ_W-1:0]     sequence_res;
  logic [ffbp_pkg::TAG_W-1:0]     frame_tag;
  logic                           keyframe_mark;
  logic                           start_mark;
  logic                           end_mark;
  logic [ffbp_pkg::INDEX_W-1:0]   fragment_index;
  logic [ffbp_pkg::INDEX_W-1:0]   fragment_total;
  logic [ffbp_pkg::LENGTH_W-1:0]  payload_length;
  logic [ffbp_pkg::SIZE_W-1:0]    payload_offset;
  logic [ffbp_pkg::PAUSE_W-1:0]   pause_us;

  modport source(output valid, status, sequence_res, frame_tag, keyframe_mark, start_mark,
                 end_mark, fragment_index, fragment_total, payload_length, payload_offset,
                 pause_us, input ready);
  modport sink(input valid, status, sequence_res, frame_tag, keyframe_mark, start_mark,
               end_mark, fragment_index, fragment_total, payload_length, payload_offset,
               pause_us, output ready);
endinterface

`default_nettype wire

FILE: design/ffbp_frag_count.sv
`default_nettype none

// fragment count of a frame: ceil(size / PAYLOAD_BYTES) by an exact reciprocal multiply
module ffbp_frag_count #(
  parameter int PAYLOAD_BYTES  = 1200,
  parameter int FRAGMENT_LIMIT = 65535
) (
  input  wire logic [ffbp_pkg::SIZE_W-1:0]  frame_size,
  output logic      [ffbp_pkg::INDEX_W-1:0] frag_count,
  output logic                              too_large
);
  import ffbp_pkg::*;

  // dividend width, shift and reciprocal, exact for every dividend below 2^XW
  localparam int XW    = $clog2((1 << SIZE_W) + PAYLOAD_BYTES);
  localparam int PLOG  = $clog2(PAYLOAD_BYTES);
  localparam int SHIFT = XW + PLOG;
  localparam int RW    = SHIFT - PLOG + 1;
  localparam int PW    = XW + RW;
  localparam int QW    = PW - SHIFT;
  localparam logic [63:0] SCALE = 64'd1 << SHIFT;
  localparam logic [RW-1:0] RECIP =
    RW'((SCALE + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES));

  logic [XW-1:0] dividend;
  logic [PW-1:0] product;
  logic [QW-1:0] quotient;

  // round up, then multiply by the reciprocal and drop the fraction
  assign dividend   = XW'(frame_size) + XW'(PAYLOAD_BYTES - 1);
  assign product    = PW'(dividend) * PW'(RECIP);
  assign quotient   = product[PW-1:SHIFT];

  assign too_large  = 32'(quotient) > 32'(FRAGMENT_LIMIT);
  assign frag_count = INDEX_W'(quotient);

endmodule

`default_nettype wire

FILE: design/frame_fragmenter_with_burst_pacing_unit.sv
// Frame fragmenter with burst pacing.
// Requests arrive on the item channel (valid/ready). A start request (kind 0)
// announces a frame by size, number and keyframe flag; the block answers with
// accepted, disabled or too large. Each next request (kind 1) returns the
// header of the next pending fragment (sequence number, marks, index, count,
// payload length and offset) and the pause in microseconds to hold after it,
// or "no fragment pending".
// Every request gives exactly one result on the result channel, held in the result
// register as the request is taken. One request is taken per cycle; the whole
// header is built by one pass of compares and adds from the frame state, with
// the fragment count coming from a single reciprocal multiply.
// The result register frees itself in the cycle it is taken, so requests keep
// flowing at one per cycle; while the receiver stalls with a result waiting,
// item.ready is low and nothing is lost.
// Registers on the APB port: 0x0 client_enabled, 0x4 pacing_mode. Write them
// only while no request is in flight. pready is always high.
// Reset (rst, synchronous) clears the frame state and the sequence counter,
// disables sending and selects light pacing.
`default_nettype none

module frame_fragmenter_with_burst_pacing_unit #(
  parameter int PAYLOAD_BYTES  = 1200,
  parameter int FRAGMENT_LIMIT = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ffbp_in_if.sink          item,
  ffbp_out_if.source       result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ffbp_pkg::*;

  localparam int LW = $clog2(PAYLOAD_BYTES + 1);

  // configuration registers
  logic  client_enabled;
  mode_t pacing_mode;

  // frame state
  logic [SEQ_W-1:0]   sequence_counter;
  logic               frame_active;
  logic [TAG_W-1:0]   held_frame_tag;
  logic               held_keyframe;
  logic [INDEX_W-1:0] next_index;
  logic [INDEX_W-1:0] total_fragments;
  logic [SIZE_W-1:0]  bytes_remaining;
  logic [SIZE_W-1:0]  byte_offset;
  logic               pacing_on;
  logic [BURST_W-1:0] burst_length;
  logic [PAUSE_W-1:0] burst_pause;
  logic [BURST_W-1:0] burst_count;

  // result register
  logic    res_valid;
  result_t res;
  result_t res_next;

  logic take;
  logic cfg_write;

  logic [INDEX_W-1:0] frag_count;
  logic               too_large;
  logic               start_ok;

  logic               p_on;
  logic [BURST_W-1:0] p_length;
  logic [PAUSE_W-1:0] p_pause;

  logic [LW-1:0]      frag_len;
  logic               frag_last;
  logic [BURST_W-1:0] count_inc;
  logic               pause_hit;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_enabled <= 1'b0;
      pacing_mode    <= MODE_LIGHT;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ENABLE: client_enabled <= pwdata[0];
        REG_MODE:   pacing_mode    <= pwdata[MODE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENABLE: prdata = {31'd0, client_enabled};
      REG_MODE:   prdata = {30'd0, pacing_mode};
    endcase
  end

  // handshake
  assign item.ready = !res_valid || result.ready;
  assign take       = item.valid && item.ready;

  // fragment count of a new frame
  ffbp_frag_count #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .FRAGMENT_LIMIT(FRAGMENT_LIMIT)
  ) u_count (
    .frame_size(item.frame_size),
    .frag_count(frag_count),
    .too_large (too_large)
  );

  assign start_ok = client_enabled && !too_large;

  // pacing rules for a new frame
  always_comb begin
    p_on     = 1'b0;
    p_length = '0;
    p_pause  = '0;
    unique case (pacing_mode)
      MODE_NONE: begin
      end
      MODE_LIGHT: begin
        p_on     = item.frame_size > LIGHT_MIN_SIZE;
        p_length = LIGHT_BURST;
        p_pause  = LIGHT_PAUSE;
      end
      MODE_AGGRESSIVE: begin
        p_on     = item.frame_size > AGGR_MIN_SIZE;
        p_length = AGGR_BURST;
        p_pause  = AGGR_PAUSE;
      end
      MODE_KEYFRAME: begin
        p_on = item.is_keyframe;
        priority if (item.is_keyframe && item.frame_size > KEY_TIER3_SIZE) begin
          p_length = KEY3_BURST;
          p_pause  = KEY3_PAUSE;
        end else if (item.is_keyframe && item.frame_size > KEY_TIER2_SIZE) begin
          p_length = KEY2_BURST;
          p_pause  = KEY2_PAUSE;
        end else if (item.is_keyframe && item.frame_size > KEY_TIER1_SIZE) begin
          p_length = KEY1_BURST;
          p_pause  = KEY1_PAUSE;
        end else begin
          p_length = KEY0_BURST;
          p_pause  = KEY0_PAUSE;
        end
      end
    endcase
  end

  // next fragment of the pending frame
  assign frag_len  = (bytes_remaining < SIZE_W'(PAYLOAD_BYTES)) ? LW'(bytes_remaining)
                                                                : LW'(PAYLOAD_BYTES);
  assign frag_last = ({1'b0, next_index} + 17'd1) >= {1'b0, total_fragments};
  assign count_inc = burst_count + 5'd1;
  assign pause_hit = pacing_on && (count_inc >= burst_length) && !frag_last;

  // result of the current request
  always_comb begin
    res_next = '0;
    if (item.kind == KIND_START) begin
      if (!client_enabled) begin
        res_next.status = ST_DISABLED;
      end else if (too_large) begin
        res_next.status = ST_TOO_LARGE;
      end else begin
        res_next.status         = ST_ACCEPTED;
        res_next.sequence_res   = sequence_counter;
        res_next.frame_tag      = item.frame_id[TAG_W-1:0];
        res_next.keyframe_mark  = item.is_keyframe;
        res_next.fragment_total = frag_count;
      end
    end else if (!frame_active) begin
      res_next.status = ST_IDLE;
    end else begin
      res_next.status         = ST_FRAGMENT;
      res_next.sequence_res   = sequence_counter;
      res_next.frame_tag      = held_frame_tag;
      res_next.keyframe_mark  = held_keyframe;
      res_next.start_mark     = next_index == '0;
      res_next.end_mark       = frag_last;
      res_next.fragment_index = next_index;
      res_next.fragment_total = total_fragments;
      res_next.payload_length = LENGTH_W'(frag_len);
      res_next.payload_offset = byte_offset;
      res_next.pause_us       = pause_hit ? burst_pause : '0;
    end
  end

  // frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter <= '0;
      frame_active     <= 1'b0;
      held_frame_tag   <= '0;
      held_keyframe    <= 1'b0;
      next_index       <= '0;
      total_fragments  <= '0;
      bytes_remaining  <= '0;
      byte_offset      <= '0;
      pacing_on        <= 1'b0;
      burst_length     <= '0;
      burst_pause      <= '0;
      burst_count      <= '0;
    end else if (take) begin
      if (item.kind == KIND_START) begin
        if (start_ok) begin
          held_frame_tag  <= item.frame_id[TAG_W-1:0];
          held_keyframe   <= item.is_keyframe;
          total_fragments <= frag_count;
          next_index      <= '0;
          bytes_remaining <= item.frame_size;
          byte_offset     <= '0;
          burst_count     <= '0;
          frame_active    <= frag_count != '0;
          pacing_on       <= p_on;
          burst_length    <= p_length;
          burst_pause     <= p_pause;
        end
      end else if (frame_active) begin
        sequence_counter <= sequence_counter + 32'd1;
        bytes_remaining  <= bytes_remaining - SIZE_W'(frag_len);
        byte_offset      <= byte_offset + SIZE_W'(frag_len);
        next_index       <= next_index + 16'd1;
        if (pacing_on) begin
          burst_count <= pause_hit ? '0 : count_inc;
        end
        if (frag_last) begin
          frame_active <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.status         = res.status;
  assign result.sequence_res   = res.sequence_res;
  assign result.frame_tag      = res.frame_tag;
  assign result.keyframe_mark  = res.keyframe_mark;
  assign result.start_mark     = res.start_mark;
  assign result.end_mark       = res.end_mark;
  assign result.fragment_index = res.fragment_index;
  assign result.fragment_total = res.fragment_total;
  assign result.payload_length = res.payload_length;
  assign result.payload_offset = res.payload_offset;
  assign result.pause_us       = res.pause_us;

  // an active frame always has fragments left
  a_active_has_fragments: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (total_fragments != '0) && (next_index < total_fragments))
    else $error("active frame without pending fragment");

  // burst count never reaches its limit while a paced frame is pending
  a_burst_below_limit: assert property (@(posedge clk) disable iff (rst)
    (frame_active && pacing_on) |-> (burst_count < burst_length))
    else $error("burst count at or above burst length");

  // a next request on an active frame yields a fragment header
  a_next_gives_fragment: assert property (@(posedge clk) disable iff (rst)
    (take && item.kind == KIND_NEXT && frame_active)
      |=> (res_valid && res.status == ST_FRAGMENT))
    else $error("next request on active frame without fragment result");

  // the sequence counter moves only on a delivered fragment
  a_sequence_step: assert property (@(posedge clk) disable iff (rst)
    !(take && item.kind == KIND_NEXT && frame_active) |=> $stable(sequence_counter))
    else $error("sequence counter moved without a fragment");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ffbp_pkg::*;

  localparam int FRAG_PAYLOAD   = 1200;
  localparam int FRAG_LIMIT     = 65535;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL     = 150;
  localparam int PHASE_COUNT    = 8;
  localparam int HALF_PHASE     = 32;

  // one request on the item channel
  typedef struct packed {
    logic                kind;
    logic [SIZE_W-1:0]   frame_size;
    logic [NUMBER_W-1:0] frame_id;
    logic                is_keyframe;
  } request_t;

  logic clk = 1'b0;
  logic rst;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ffbp_in_if  item_ch();
  ffbp_out_if result_ch();

  frame_fragmenter_with_burst_pacing_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // request traffic and its bookkeeping
  request_t pending_requests[$];
  result_t  expected_headers[$];
  int unsigned requests_queued  = 0;
  int unsigned requests_offered = 0;
  int unsigned requests_taken   = 0;
  int unsigned send_idle_pct    = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned long_stall_reqs  = 0;
  int unsigned mismatches       = 0;
  int unsigned headers_checked  = 0;
  int unsigned frames_accepted  = 0;
  int unsigned fragments_seen   = 0;
  int unsigned pauses_seen      = 0;
  int unsigned rejects_seen     = 0;

  // register shadow, starting from reset values
  logic  cfg_enabled = 1'b0;
  mode_t cfg_mode    = MODE_LIGHT;

  // fragmenter state, starting from reset values
  logic [SEQ_W-1:0]   seq_count  = '0;
  logic               frame_open = 1'b0;
  logic [TAG_W-1:0]   tag_held   = '0;
  logic               key_held   = 1'b0;
  logic [INDEX_W-1:0] idx_next   = '0;
  logic [INDEX_W-1:0] frag_total = '0;
  logic [SIZE_W-1:0]  bytes_left = '0;
  logic [SIZE_W-1:0]  offset_now = '0;
  logic               paced      = 1'b0;
  logic [BURST_W-1:0] burst_len  = '0;
  logic [PAUSE_W-1:0] burst_gap  = '0;
  logic [BURST_W-1:0] burst_run  = '0;

  // header the block should return for one request; advances the frame state
  function automatic result_t next_header(logic kind, logic [SIZE_W-1:0] size,
                                          logic [NUMBER_W-1:0] number, logic key);
    result_t hdr;
    logic [31:0] frags;
    logic [LENGTH_W-1:0] len;
    logic last;
    hdr = '0;
    if (kind == KIND_START) begin
      frags = (32'(size) + FRAG_PAYLOAD - 1) / FRAG_PAYLOAD;
      if (!cfg_enabled) begin
        hdr.status = ST_DISABLED;
      end else if (frags > FRAG_LIMIT) begin
        hdr.status = ST_TOO_LARGE;
      end else begin
        tag_held   = number[TAG_W-1:0];
        key_held   = key;
        frag_total = frags[INDEX_W-1:0];
        idx_next   = '0;
        bytes_left = size;
        offset_now = '0;
        burst_run  = '0;
        frame_open = (frags != 0);
        // pacing rules are fixed for the frame at acceptance
        paced     = 1'b0;
        burst_len = '0;
        burst_gap = '0;
        case (cfg_mode)
          MODE_LIGHT: begin
            paced     = (size > LIGHT_MIN_SIZE);
            burst_len = LIGHT_BURST;
            burst_gap = LIGHT_PAUSE;
          end
          MODE_AGGRESSIVE: begin
            paced     = (size > AGGR_MIN_SIZE);
            burst_len = AGGR_BURST;
            burst_gap = AGGR_PAUSE;
          end
          MODE_KEYFRAME: begin
            paced = key;
            if (key && size > KEY_TIER3_SIZE) begin
              burst_len = KEY3_BURST;
              burst_gap = KEY3_PAUSE;
            end else if (key && size > KEY_TIER2_SIZE) begin
              burst_len = KEY2_BURST;
              burst_gap = KEY2_PAUSE;
            end else if (key && size > KEY_TIER1_SIZE) begin
              burst_len = KEY1_BURST;
              burst_gap = KEY1_PAUSE;
            end else begin
              burst_len = KEY0_BURST;
              burst_gap = KEY0_PAUSE;
            end
          end
          default: ;
        endcase
        hdr.status         = ST_ACCEPTED;
        hdr.sequence_res   = seq_count;
        hdr.frame_tag      = tag_held;
        hdr.keyframe_mark  = key_held;
        hdr.fragment_total = frag_total;
      end
    end else if (!frame_open) begin
      hdr.status = ST_IDLE;
    end else begin
      len  = (bytes_left < FRAG_PAYLOAD) ? bytes_left[LENGTH_W-1:0] : LENGTH_W'(FRAG_PAYLOAD);
      last = (32'(idx_next) + 1 >= 32'(frag_total));
      hdr.status         = ST_FRAGMENT;
      hdr.sequence_res   = seq_count;
      hdr.frame_tag      = tag_held;
      hdr.keyframe_mark  = key_held;
      hdr.start_mark     = (idx_next == 0);
      hdr.end_mark       = last;
      hdr.fragment_index = idx_next;
      hdr.fragment_total = frag_total;
      hdr.payload_length = len;
      hdr.payload_offset = offset_now;
      seq_count  = seq_count + 32'd1;
      bytes_left = bytes_left - SIZE_W'(len);
      offset_now = offset_now + SIZE_W'(len);
      // pause only inside a frame, after a full burst
      if (paced) begin
        burst_run = burst_run + 5'd1;
        if (burst_run >= burst_len && !last) begin
          hdr.pause_us = burst_gap;
          burst_run    = '0;
        end
      end
      idx_next = idx_next + 16'd1;
      if (last) frame_open = 1'b0;
    end
    return hdr;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor: request acceptance, result checking, watchdog
  always @(posedge clk) begin : monitor
    result_t want;
    logic item_fire;
    logic result_fire;
    int unsigned quiet_cycles;
    item_fire   = !rst && item_ch.valid && item_ch.ready;
    result_fire = !rst && result_ch.valid && result_ch.ready;
    if (result_fire) begin
      if (expected_headers.size() == 0) begin
        $display("%0t ns: result with no request waiting, status %0d", $time, result_ch.status);
        mismatches++;
      end else begin
        want = expected_headers.pop_front();
        check_field("status", 32'(want.status), 32'(result_ch.status));
        check_field("sequence_res", want.sequence_res, result_ch.sequence_res);
        check_field("frame_tag", 32'(want.frame_tag), 32'(result_ch.frame_tag));
        check_field("keyframe_mark", 32'(want.keyframe_mark), 32'(result_ch.keyframe_mark));
        check_field("start_mark", 32'(want.start_mark), 32'(result_ch.start_mark));
        check_field("end_mark", 32'(want.end_mark), 32'(result_ch.end_mark));
        check_field("fragment_index", 32'(want.fragment_index),
                    32'(result_ch.fragment_index));
        check_field("fragment_total", 32'(want.fragment_total),
                    32'(result_ch.fragment_total));
        check_field("payload_length", 32'(want.payload_length),
                    32'(result_ch.payload_length));
        check_field("payload_offset", 32'(want.payload_offset),
                    32'(result_ch.payload_offset));
        check_field("pause_us", 32'(want.pause_us), 32'(result_ch.pause_us));
        headers_checked++;
        case (want.status)
          ST_FRAGMENT: begin
            fragments_seen++;
            if (want.pause_us != 0) pauses_seen++;
          end
          ST_ACCEPTED:  frames_accepted++;
          ST_DISABLED:  rejects_seen++;
          ST_TOO_LARGE: rejects_seen++;
          default: ;
        endcase
      end
    end
    if (item_fire) begin
      expected_headers.push_back(next_header(item_ch.kind, item_ch.frame_size,
                                             item_ch.frame_id, item_ch.is_keyframe));
      requests_taken++;
    end
    if (rst || item_fire || result_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin : driver
    request_t req;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || requests_taken == requests_offered) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= req.kind;
        item_ch.frame_size  <= req.frame_size;
        item_ch.frame_id    <= req.frame_id;
        item_ch.is_keyframe <= req.is_keyframe;
        requests_offered++;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin : receiver
    int unsigned stall_left;
    int unsigned stalls_served;
    if (long_stall_reqs != stalls_served) begin
      stalls_served = long_stall_reqs;
      stall_left    = LONG_STALL;
    end
    if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic reg_write(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ENABLE) cfg_enabled = value[0];
    else cfg_mode = value[MODE_W-1:0];
    @(posedge clk);
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    do @(negedge clk);
    while (requests_taken != requests_queued || expected_headers.size() != 0);
    repeat (4) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic queue_request(logic kind, logic [SIZE_W-1:0] size,
                               logic [NUMBER_W-1:0] number, logic key);
    request_t req;
    req.kind        = kind;
    req.frame_size  = size;
    req.frame_id    = number;
    req.is_keyframe = key;
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(0, 9))
      0:       return SIZE_W'($urandom_range(0, 1200));
      1, 2, 3: return SIZE_W'($urandom_range(1, 12000));
      4, 5:    return SIZE_W'($urandom_range(12001, 60000));
      6:       return SIZE_W'($urandom_range(60001, 120000));
      7:       return SIZE_W'($urandom_range(100001, 700000));
      8:       return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(78641000, 78643000));
    endcase
  endfunction

  // mostly whole or partial frames, some stray next requests
  task automatic queue_random_traffic(int quota);
    int added;
    int nexts;
    logic [SIZE_W-1:0] size;
    logic [31:0] frags;
    added = 0;
    while (added < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(KIND_NEXT, SIZE_W'($urandom), $urandom, 1'($urandom));
        added++;
      end else begin
        size  = random_size();
        frags = (32'(size) + FRAG_PAYLOAD - 1) / FRAG_PAYLOAD;
        nexts = $urandom_range(1, 45);
        if (frags < 45 && $urandom_range(0, 1) == 1) nexts = frags + $urandom_range(0, 1);
        queue_request(KIND_START, size, $urandom, 1'($urandom));
        repeat (nexts) queue_request(KIND_NEXT, SIZE_W'($urandom), $urandom, 1'($urandom));
        added += 1 + nexts;
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    mode_t phase_modes[PHASE_COUNT];
    phase_modes = '{MODE_NONE, MODE_LIGHT, MODE_AGGRESSIVE, MODE_KEYFRAME,
                    MODE_KEYFRAME, MODE_AGGRESSIVE, MODE_LIGHT, MODE_NONE};
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out of reset: nothing pending, sending disabled
    queue_request(KIND_NEXT, '0, '0, 1'b0);
    queue_request(KIND_START, 27'd5000, 32'd7, 1'b1);
    drain();
    reg_write(REG_ENABLE, 32'd1);
    reg_write(REG_MODE, 32'(MODE_NONE));

    // empty frame, single byte frame, frame with a one byte tail
    queue_request(KIND_START, '0, 32'hFFFF_FFFF, 1'b1);
    queue_request(KIND_NEXT, '0, '0, 1'b0);
    queue_request(KIND_START, 27'd1, '0, 1'b0);
    queue_request(KIND_NEXT, '0, '0, 1'b0);
    queue_request(KIND_START, 27'd1201, 32'h1234_ABCD, 1'b1);
    repeat (3) queue_request(KIND_NEXT, '1, '1, 1'b1);
    // largest frame that fits, rejects in the middle of it, then replaced
    queue_request(KIND_START, 27'd78642000, 32'hFFFF_0000, 1'b1);
    repeat (2) queue_request(KIND_NEXT, '0, '0, 1'b0);
    queue_request(KIND_START, 27'd78642001, 32'h0000_5555, 1'b0);
    queue_request(KIND_NEXT, '0, '0, 1'b0);
    queue_request(KIND_START, '1, '1, 1'b1);
    queue_request(KIND_START, 27'd2400, 32'h0000_FFFF, 1'b0);
    repeat (2) queue_request(KIND_NEXT, '0, '0, 1'b0);
    drain();

    // keyframe pacing on the top size tier
    reg_write(REG_MODE, 32'(MODE_KEYFRAME));
    queue_request(KIND_START, 27'd600000, 32'hA5A5_5A5A, 1'b1);
    repeat (3) queue_request(KIND_NEXT, '0, '0, 1'b0);
    drain();

    // disable and change mode mid-frame: pending fragments keep old rules
    reg_write(REG_ENABLE, 32'd0);
    reg_write(REG_MODE, 32'(MODE_AGGRESSIVE));
    repeat (2) queue_request(KIND_NEXT, '0, '0, 1'b0);
    queue_request(KIND_START, 27'd3000, 32'd1, 1'b0);
    drain();

    // random phases across pacing modes and idle patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      reg_write(REG_MODE, 32'(phase_modes[p]));
      reg_write(REG_ENABLE, 32'd1);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      queue_random_traffic(HALF_PHASE);
      // receiver holds off while the sender keeps offering
      if (p == 0) long_stall_reqs++;
      // sender pauses until every result is back
      if (p == 3) drain();
      queue_random_traffic(HALF_PHASE);
      drain();
    end

    repeat (10) @(negedge clk);
    $display("covered %0d results: %0d frames accepted, %0d fragments, %0d paced pauses,",
             headers_checked, frames_accepted, fragments_seen, pauses_seen);
    $display("%0d rejected starts, all four pacing modes, enable on and off", rejects_seen);
    if (mismatches == 0 && expected_headers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ffbp_pkg.sv
design/ffbp_in_if.sv
design/ffbp_out_if.sv
design/ffbp_frag_count.sv
design/frame_fragmenter_with_burst_pacing_unit.sv
tb/tb.sv
